@@ src/zbdt_pkg.sv @@
package zbdt_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int ID_BITS       = 16;
  localparam int ADDR_BITS     = 16;
  localparam int NUM_BITS      = 40;
  localparam int QUO_BITS      = 40;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TEST  = 2'd1,
    OP_READ  = 2'd2,
    OP_OTHER = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_SETUP,
    ST_DIV,
    ST_SUM,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [15:0]        triangle_id;
    logic [31:0]        vertex1_xy;
    logic [31:0]        vertex2_xy;
    logic [31:0]        vertex3_xy;
    logic signed [23:0] vertex1_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } in_t;

  typedef struct packed {
    logic               covered;
    logic               won;
    logic               has_triangle;
    logic [15:0]        stored_id;
    logic signed [23:0] stored_depth;
  } out_t;

endpackage

@@ src/zbuffer_fragment_depth_test.sv @@
// Channel   Signals                    Transfer
// command   start, busy, cmd           start & !busy
// result    done, result               done (one cycle, no back-pressure)
// config    far_depth_we, far_depth_wd far_depth_we
//
// Clear/read: EDGE, WRITE. Test outside the edges: EDGE, SETUP, WRITE. A test inside
// also runs DIV, SUM: a radix-2 divider produces one of 40 quotient bits per cycle.
// Pixel state sits in one single-port RAM with a registered read.
// rst clears control and sets far_depth; RAM contents are undefined.
// busy holds from transfer until the done cycle; results cannot be stalled.
module zbuffer_fragment_depth_test (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  zbdt_pkg::in_t      cmd,
  output logic               done,
  output zbdt_pkg::out_t     result,
  input  logic               far_depth_we,
  input  logic signed [23:0] far_depth_wd
);

  logic [40:0] mem [0:(1 << zbdt_pkg::ADDR_BITS) - 1];
  logic [40:0] rd;

  zbdt_pkg::state_t state, state_next;
  zbdt_pkg::in_t    item;
  logic signed [23:0] far_depth;
  logic [5:0]  cnt;
  logic        hit;
  logic        neg;
  logic [zbdt_pkg::NUM_BITS-1:0] rem, quo, dvs;
  logic signed [zbdt_pkg::NUM_BITS-1:0] num;
  logic signed [23:0] znew;
  logic        offscr;

  logic [zbdt_pkg::ADDR_BITS-1:0] addr;
  logic        we;
  logic [40:0] wd;

  logic signed [17:0] px, py;
  logic signed [17:0] ax, ay, bx, by, cx, cy;
  logic signed [36:0] e1, e2, e3;
  logic signed [34:0] pnx, pny;
  logic [zbdt_pkg::NUM_BITS:0] trial;
  logic signed [zbdt_pkg::NUM_BITS+1:0] zsum;

  assign addr = {item.pixel_y, item.pixel_x};

  always_comb begin
    px = $signed({2'b0, item.pixel_x, 4'b0}) - 18'(zbdt_pkg::SCREEN_WIDTH * 8);
    py = 18'(zbdt_pkg::SCREEN_HEIGHT * 8) - $signed({2'b0, item.pixel_y, 4'b0});
    ax = px - 18'($signed(item.vertex1_xy[31:16]));
    ay = py - 18'($signed(item.vertex1_xy[15:0]));
    bx = px - 18'($signed(item.vertex2_xy[31:16]));
    by = py - 18'($signed(item.vertex2_xy[15:0]));
    cx = px - 18'($signed(item.vertex3_xy[31:16]));
    cy = py - 18'($signed(item.vertex3_xy[15:0]));
    e1 = 37'(ax * by) - 37'(ay * bx);
    e2 = 37'(bx * cy) - 37'(by * cx);
    e3 = 37'(cx * ay) - 37'(cy * ax);
    pnx = 35'(item.normal_x * (-ax));
    pny = 35'(item.normal_y * (-ay));
    trial = {rem, quo[zbdt_pkg::NUM_BITS-1]} - {1'b0, dvs};
    zsum = 42'(item.vertex1_z) + (neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo}));
  end

  always_comb begin
    offscr = (32'(item.pixel_x) >= zbdt_pkg::SCREEN_WIDTH) ||
             (32'(item.pixel_y) >= zbdt_pkg::SCREEN_HEIGHT);
  end

  always_comb begin
    state_next = state;
    case (state)
      zbdt_pkg::ST_IDLE:  if (start) state_next = zbdt_pkg::ST_EDGE;
      zbdt_pkg::ST_EDGE: begin
        if (offscr || item.operation != zbdt_pkg::OP_TEST) begin
          state_next = zbdt_pkg::ST_WRITE;
        end else begin
          state_next = zbdt_pkg::ST_SETUP;
        end
      end
      zbdt_pkg::ST_SETUP: state_next = hit ? zbdt_pkg::ST_DIV : zbdt_pkg::ST_WRITE;
      zbdt_pkg::ST_DIV:   if (cnt == 6'd0) state_next = zbdt_pkg::ST_SUM;
      zbdt_pkg::ST_SUM:   state_next = zbdt_pkg::ST_WRITE;
      zbdt_pkg::ST_WRITE: state_next = zbdt_pkg::ST_IDLE;
      default:            state_next = zbdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != zbdt_pkg::ST_IDLE);
    we = 1'b0;
    wd = rd;
    result = '0;
    done = (state == zbdt_pkg::ST_WRITE);
    if (done) begin
      if (offscr) begin
        result.stored_depth = far_depth;
      end else if (item.operation == zbdt_pkg::OP_CLEAR) begin
        we = 1'b1;
        wd = {1'b0, 16'd0, far_depth};
        result.stored_depth = far_depth;
      end else begin
        if (item.operation == zbdt_pkg::OP_TEST && hit) begin
          result.covered = 1'b1;
          if (znew < $signed(rd[23:0])) begin
            we = 1'b1;
            wd = {1'b1, 16'(item.triangle_id[zbdt_pkg::ID_BITS-1:0]), znew};
            result.won = 1'b1;
          end
        end
        result.has_triangle = wd[40];
        result.stored_id    = wd[39:24];
        result.stored_depth = wd[23:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wd;
    rd <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zbdt_pkg::ST_IDLE;
      far_depth <= 24'sh7FFFFF;
    end else begin
      state <= state_next;
      if (far_depth_we) far_depth <= far_depth_wd;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      zbdt_pkg::ST_IDLE: begin
        if (start) item <= cmd;
        hit <= 1'b0;
      end
      zbdt_pkg::ST_EDGE: begin
        hit <= ((e1 <= 0) && (e2 <= 0) && (e3 <= 0)) ||
               ((e1 >= 0) && (e2 >= 0) && (e3 >= 0));
        num <= 40'(36'(pnx) + 36'(pny)) <<< 4;
      end
      zbdt_pkg::ST_SETUP: begin
        hit <= hit && (item.normal_z != 16'sd0);
        neg <= num[zbdt_pkg::NUM_BITS-1] ^ item.normal_z[15];
        quo <= num[zbdt_pkg::NUM_BITS-1] ? 40'(-num) : 40'(num);
        dvs <= item.normal_z[15] ? 40'(-41'(item.normal_z)) : 40'(item.normal_z);
        rem <= '0;
        cnt <= 6'(zbdt_pkg::QUO_BITS - 1);
      end
      zbdt_pkg::ST_DIV: begin
        if (!trial[zbdt_pkg::NUM_BITS]) begin
          rem <= trial[zbdt_pkg::NUM_BITS-1:0];
          quo <= {quo[zbdt_pkg::NUM_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[zbdt_pkg::NUM_BITS-2:0], quo[zbdt_pkg::NUM_BITS-1]};
          quo <= {quo[zbdt_pkg::NUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
      end
      zbdt_pkg::ST_SUM: begin
        if (zsum > 42'sd8388607) begin
          znew <= 24'sh7FFFFF;
        end else if (zsum < -42'sd8388608) begin
          znew <= 24'sh800000;
        end else begin
          znew <= zsum[23:0];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/zbdt_checker.sv @@
module zbdt_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input zbdt_pkg::out_t result
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transfer did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");

  a_won_cov: assert property (@(posedge clk) disable iff (rst)
    done && result.won |-> result.covered && result.has_triangle)
    else $error("won without cover");

endmodule

bind zbuffer_fragment_depth_test zbdt_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

@@ sim/tb_zbuffer_fragment_depth_test.sv @@
module tb_zbuffer_fragment_depth_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_RANDOM     = 740;
  localparam int TAIL_CYCLES    = 60;

  typedef struct {
    zbdt_pkg::in_t  cmd;
    bit             typed;
    zbdt_pkg::out_t want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  zbdt_pkg::in_t      cmd;
  logic               done;
  zbdt_pkg::out_t     result;
  logic               far_depth_we;
  logic signed [23:0] far_depth_wd;

  logic signed [23:0] far_model;
  logic signed [23:0] depth_mem [65536];
  logic [15:0]        id_mem [65536];
  bit                 valid_mem [65536];
  bit                 written [65536];

  zbdt_pkg::out_t pending[$];
  row_t      directed[$];
  int        errors;
  int        idle_cycles;
  int        n_sent;
  int        n_done;
  int        n_covered;
  int        n_won;
  bit        allow_idle;
  bit [15:0] pool [16];

  zbuffer_fragment_depth_test i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .result       (result),
    .far_depth_we (far_depth_we),
    .far_depth_wd (far_depth_wd)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [31:0] pack_xy(longint x, longint y);
    logic [15:0] hx;
    logic [15:0] hy;
    hx = x[15:0];
    hy = y[15:0];
    return {hx, hy};
  endfunction

  function automatic zbdt_pkg::in_t make_cmd(zbdt_pkg::op_t op, int x, int y, int id,
                                             logic [31:0] v1, logic [31:0] v2,
                                             logic [31:0] v3, int z1,
                                             int nx, int ny, int nz);
    zbdt_pkg::in_t c;
    c.operation   = op;
    c.pixel_x     = x[7:0];
    c.pixel_y     = y[7:0];
    c.triangle_id = id[15:0];
    c.vertex1_xy  = v1;
    c.vertex2_xy  = v2;
    c.vertex3_xy  = v3;
    c.vertex1_z   = z1[23:0];
    c.normal_x    = nx[15:0];
    c.normal_y    = ny[15:0];
    c.normal_z    = nz[15:0];
    return c;
  endfunction

  function automatic void add_row(zbdt_pkg::in_t c, bit typed, zbdt_pkg::out_t want);
    row_t r;
    r.cmd   = c;
    r.typed = typed;
    r.want  = want;
    directed = {directed, r};
  endfunction

  function automatic zbdt_pkg::out_t depth_test_predict(zbdt_pkg::in_t c);
    zbdt_pkg::out_t r;
    int     a;
    longint px, py, x1, y1, x2, y2, x3, y3, nx, ny, nz;
    longint e1, e2, e3, num, z;
    a  = int'({c.pixel_y, c.pixel_x});
    r  = '0;
    if (c.operation == zbdt_pkg::OP_CLEAR) begin
      depth_mem[a] = far_model;
      id_mem[a]    = '0;
      valid_mem[a] = 1'b0;
    end else if (c.operation == zbdt_pkg::OP_TEST) begin
      px = longint'(c.pixel_x) * 16 - zbdt_pkg::SCREEN_WIDTH * 8;
      py = zbdt_pkg::SCREEN_HEIGHT * 8 - longint'(c.pixel_y) * 16;
      x1 = longint'($signed(c.vertex1_xy[31:16]));
      y1 = longint'($signed(c.vertex1_xy[15:0]));
      x2 = longint'($signed(c.vertex2_xy[31:16]));
      y2 = longint'($signed(c.vertex2_xy[15:0]));
      x3 = longint'($signed(c.vertex3_xy[31:16]));
      y3 = longint'($signed(c.vertex3_xy[15:0]));
      nx = longint'(c.normal_x);
      ny = longint'(c.normal_y);
      nz = longint'(c.normal_z);
      e1 = (px - x1) * (py - y2) - (py - y1) * (px - x2);
      e2 = (px - x2) * (py - y3) - (py - y2) * (px - x3);
      e3 = (px - x3) * (py - y1) - (py - y3) * (px - x1);
      if (((e1 <= 0 && e2 <= 0 && e3 <= 0) || (e1 >= 0 && e2 >= 0 && e3 >= 0))
          && nz != 0) begin
        num = (nx * (x1 - px) + ny * (y1 - py)) * 16;
        z   = longint'(c.vertex1_z) + num / nz;
        if (z > 8388607) z = 8388607;
        if (z < -8388608) z = -8388608;
        r.covered = 1'b1;
        if (z < longint'(depth_mem[a])) begin
          r.won        = 1'b1;
          depth_mem[a] = z[23:0];
          id_mem[a]    = c.triangle_id;
          valid_mem[a] = 1'b1;
        end
      end
    end
    r.has_triangle = valid_mem[a];
    r.stored_id    = id_mem[a];
    r.stored_depth = depth_mem[a];
    return r;
  endfunction

  always @(posedge clk) begin
    zbdt_pkg::out_t want;
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, pending.size());
        $display("FAILURE");
        $finish;
      end
      if (done) begin
        n_done <= n_done + 1;
        if (pending.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          errors <= errors + 1;
        end else begin
          want = pending.pop_front();
          if (result !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, result);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  task automatic issue(zbdt_pkg::in_t c, bit typed, zbdt_pkg::out_t want);
    zbdt_pkg::out_t model;
    @(negedge clk);
    if (allow_idle && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    model = depth_test_predict(c);
    written[{c.pixel_y, c.pixel_x}] = written[{c.pixel_y, c.pixel_x}] |
                                      (c.operation == zbdt_pkg::OP_CLEAR);
    pending = {pending, (typed ? want : model)};
    n_sent++;
    if (model.covered) n_covered++;
    if (model.won) n_won++;
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_far(logic signed [23:0] v);
    settle();
    far_depth_we <= 1'b1;
    far_depth_wd <= v;
    @(negedge clk);
    far_depth_we <= 1'b0;
    far_model = v;
  endtask

  task automatic random_item();
    zbdt_pkg::in_t c;
    int     sel, x, y, r;
    longint px, py;
    sel = $urandom_range(99);
    if ($urandom_range(99) < 70) begin
      r = $urandom_range(15);
      x = int'(pool[r][7:0]);
      y = int'(pool[r][15:8]);
    end else begin
      x = $urandom_range(255);
      y = $urandom_range(255);
    end
    px = longint'(x) * 16 - 2048;
    py = 2048 - longint'(y) * 16;
    c = make_cmd(zbdt_pkg::OP_TEST, x, y, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom_range(0, 32768) - 16384,
                 $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
    if ($urandom_range(9) == 0) c.normal_z = '0;
    if ($urandom_range(99) < 75) begin
      c.vertex1_xy = pack_xy(px - $urandom_range(3000), py - $urandom_range(3000));
      c.vertex2_xy = pack_xy(px + $urandom_range(3000), py - $urandom_range(3000));
      c.vertex3_xy = pack_xy(px + $urandom_range(3000) - 1500, py + $urandom_range(3000));
      if ($urandom_range(1)) {c.vertex2_xy, c.vertex3_xy} = {c.vertex3_xy, c.vertex2_xy};
      if ($urandom_range(1)) c.vertex1_z = 24'(int'($urandom_range(0, 8192)) - 4096);
    end
    if (sel < 10) c.operation = zbdt_pkg::OP_CLEAR;
    else if (sel < 30) c.operation = zbdt_pkg::OP_READ;
    else if (sel < 38) c.operation = zbdt_pkg::OP_OTHER;
    if (c.operation != zbdt_pkg::OP_CLEAR && !written[{c.pixel_y, c.pixel_x}]) begin
      issue(make_cmd(zbdt_pkg::OP_CLEAR, x, y, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    end
    issue(c, 1'b0, '0);
  endtask

  initial begin
    zbdt_pkg::out_t far_max;
    logic [31:0] bv1, bv2, bv3;
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    far_depth_we = 1'b0;
    far_depth_wd = '0;
    far_model    = 24'sd8388607;
    errors       = 0;
    idle_cycles  = 0;
    n_sent       = 0;
    n_done       = 0;
    n_covered    = 0;
    n_won        = 0;
    allow_idle   = 1'b1;
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    pool[2] = 16'h8080;
    for (int i = 3; i < 16; i++) pool[i] = 16'($urandom);

    bv1 = pack_xy(-30000, -30000);
    bv2 = pack_xy(30000, -30000);
    bv3 = pack_xy(0, 30000);
    far_max = '{covered: 1'b0, won: 1'b0, has_triangle: 1'b0, stored_id: '0,
                stored_depth: 24'sd8388607};
    add_row(make_cmd(zbdt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, far_max);
    add_row(make_cmd(zbdt_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, far_max);
    add_row(make_cmd(zbdt_pkg::OP_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, far_max);
    add_row(make_cmd(zbdt_pkg::OP_CLEAR, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0), 1, far_max);
    add_row(make_cmd(zbdt_pkg::OP_CLEAR, 128, 128, 0, 0, 0, 0, 0, 0, 0, 0), 1, far_max);
    add_row(make_cmd(zbdt_pkg::OP_TEST, 128, 128, 5, bv1, bv2, bv3, 0, 0, 0, 0),
            1, far_max);
    add_row(make_cmd(zbdt_pkg::OP_TEST, 128, 128, 16'hFFFF, bv1, bv2, bv3, 256, 0, 0,
                     16384),
            1, '{1'b1, 1'b1, 1'b1, 16'hFFFF, 24'sd256});
    add_row(make_cmd(zbdt_pkg::OP_TEST, 128, 128, 7, bv1, bv2, bv3, 256, 0, 0, 16384),
            1, '{1'b1, 1'b0, 1'b1, 16'hFFFF, 24'sd256});
    add_row(make_cmd(zbdt_pkg::OP_TEST, 128, 128, 1, bv3, bv2, bv1, -8388608, 0, 0,
                     -16384),
            1, '{1'b1, 1'b1, 1'b1, 16'h0001, -24'sd8388608});
    add_row(make_cmd(zbdt_pkg::OP_TEST, 0, 0, 3, pack_xy(1000, 0), pack_xy(2000, 0),
                     pack_xy(1500, 900), 0, 100, 100, 100), 0, '0);
    add_row(make_cmd(zbdt_pkg::OP_TEST, 0, 0, 9, pack_xy(-2048, 2048), pack_xy(0, 2048),
                     pack_xy(-2048, 0), 100, 16384, -16384, 16384), 0, '0);
    add_row(make_cmd(zbdt_pkg::OP_TEST, 0, 0, 10, pack_xy(-2048, 2048),
                     pack_xy(-2048, 0), pack_xy(0, 2048), -100, -16384, 16384, 1),
            0, '0);
    add_row(make_cmd(zbdt_pkg::OP_TEST, 255, 255, 11, bv1, bv2, bv3, 8388607, -16384,
                     16384, 1), 0, '0);
    add_row(make_cmd(zbdt_pkg::OP_TEST, 255, 255, 12, pack_xy(-32768, 32767),
                     pack_xy(32767, 32767), pack_xy(0, -32768), 0, 16384, -16384, -1),
            0, '0);
    add_row(make_cmd(zbdt_pkg::OP_READ, 255, 255, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) issue(directed[i].cmd, directed[i].typed, directed[i].want);

    write_far(24'($urandom));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      allow_idle = !(i >= 240 && i < 400);
      if (i == 200) write_far(-24'sd8388608);
      if (i == 400) write_far(24'sd8388607);
      if (i == 600) write_far(24'($urandom));
      random_item();
    end
    settle();

    $display("Sent %0d commands, checked %0d results: %0d covered tests, %0d depth wins.",
             n_sent, n_done, n_covered, n_won);
    $display("far_depth was set to reset, both extremes and random values.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
